### hw/rtl/clvp_pkg.sv
// Shared types and fixed-point constants for the curvature-limited velocity profile.
package clvp_pkg;

  // Field widths
  localparam int PT_XW  = 24;
  localparam int PT_HW  = 17;
  localparam int PT_W   = 2 * PT_XW + PT_HW;
  localparam int SPD_W  = 17;
  localparam int STP_W  = 25;
  localparam int KW     = 27;
  localparam int CUM_W  = 32;

  // Shared multiplier
  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;

  // Iterative divider and square root
  localparam int DIV_NW = 41;
  localparam int DIV_DW = 44;
  localparam int DIV_CW = $clog2(DIV_NW + 1);
  localparam int SQ_W   = 52;
  localparam int SQ_RW  = SQ_W / 2;
  localparam int SQ_CW  = $clog2(SQ_RW + 1);

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;
  localparam logic [CFG_IW-1:0] CFG_LOOK_AHEAD = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_CURVE_GAIN = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_SPEED  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ACCEL      = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_END_SPEED  = 3'd4;

  // Constants
  localparam logic [SPD_W-1:0]  ONE_Q16        = 17'h10000;
  localparam logic signed [17:0] HALF_TURN     = 18'sd23040;
  localparam logic signed [17:0] FULL_TURN     = 18'sd46080;
  localparam logic [MUL_W-1:0]  PI_OVER_90_Q32 = 28'd149922641;

  // Status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### hw/rtl/clvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/clvp_div.sv
// Restoring divider, one quotient bit per cycle.
module clvp_div
  import clvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output unit_stat_t        stat,
  output logic [DIV_NW-1:0] quo
);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  // Shift in the next numerator bit and try the subtract
  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      num_r <= {num_r[DIV_NW-2:0], 1'b0};
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

### hw/rtl/clvp_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module clvp_sqrt
  import clvp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SQ_W-1:0]  val,
  output unit_stat_t       stat,
  output logic [SQ_RW-1:0] root
);

  logic [SQ_W-1:0]  v_r;
  logic [SQ_W-1:0]  r_r;
  logic [SQ_W-1:0]  bit_r;
  logic [SQ_CW-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SQ_W-1:0]  t;

  assign t = r_r + bit_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SQ_CW'(SQ_RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == SQ_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= val;
      r_r   <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      if (v_r >= t) begin
        v_r <= v_r - t;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = r_r[SQ_RW-1:0];

endmodule

### hw/rtl/curvature_limited_velocity_profile.sv
// Top level: waypoint store, sequencer and shared arithmetic for the velocity profile.
//
// Waypoints arrive on the in_ stream, one transaction each. Up to MAX_POINTS are held;
// further ones are dropped. The transaction with in_tlast high ends the path and starts
// the computation over the held points; in_tready stays low until the last speed of the
// path has been taken. Speeds leave on the out_ stream in waypoint order, with out_tlast
// on the final one. A stalled receiver simply holds the sequencer in its output wait.
// Per path of n points the work is:
//   geometry  one 26-step square root and one 41-step division per segment
//   ceiling   one division per point, after a scan of its look-ahead window
//   ramps     one 26-step square root per segment, forward and then backward
//   output    one speed per point, plus receiver stall
// The user is to write configuration through the cfg_ port only while the block is idle;
// the block itself does not enforce this. After reset the held point count is zero and
// the registers take their default values.
module curvature_limited_velocity_profile
  import clvp_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [71:0]       in_tdata,   // pos_x[23:0], pos_y[47:24], heading_deg[64:48]
  input  logic              in_tlast,   // is_last
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // speed[16:0]
  output logic              out_tlast,  // final_point
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [28:0] {
    S_LOAD   = 29'h1 << 0,
    S_ONE    = 29'h1 << 1,
    S_G_RD0  = 29'h1 << 2,
    S_G_PREV = 29'h1 << 3,
    S_G_RD   = 29'h1 << 4,
    S_G_DX   = 29'h1 << 5,
    S_G_DY   = 29'h1 << 6,
    S_G_SQ   = 29'h1 << 7,
    S_G_SQW  = 29'h1 << 8,
    S_G_DIV  = 29'h1 << 9,
    S_G_DIVW = 29'h1 << 10,
    S_G_TAIL = 29'h1 << 11,
    S_C_RD   = 29'h1 << 12,
    S_C_K    = 29'h1 << 13,
    S_C_CHK  = 29'h1 << 14,
    S_C_WIN  = 29'h1 << 15,
    S_C_MUL  = 29'h1 << 16,
    S_C_DEN  = 29'h1 << 17,
    S_C_DIVW = 29'h1 << 18,
    S_F_INIT = 29'h1 << 19,
    S_R_RD   = 29'h1 << 20,
    S_R_SQ   = 29'h1 << 21,
    S_R_AS   = 29'h1 << 22,
    S_R_ST   = 29'h1 << 23,
    S_R_W    = 29'h1 << 24,
    S_F_END  = 29'h1 << 25,
    S_O_RD   = 29'h1 << 26,
    S_O_LD   = 29'h1 << 27,
    S_O_W    = 29'h1 << 28
  } state_t;

  // Configuration registers
  logic [23:0]      look_r;
  logic [15:0]      gain_r;
  logic [SPD_W-1:0] minsp_r;
  logic [23:0]      accel_r;
  logic [SPD_W-1:0] endsp_r;

  // Sequencer registers
  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic             back_r, back_nxt;
  logic             oval_r, oval_nxt;
  logic             olast_r, olast_nxt;
  logic [SPD_W-1:0] ospd_r, ospd_nxt;

  // Datapath registers
  logic [PT_XW-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [PT_XW-1:0] cur_y_r, cur_y_nxt;
  logic [PT_HW-1:0] prev_h_r, prev_h_nxt, cur_h_r, cur_h_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [STP_W-1:0] d_r, d_nxt;
  logic [KW-1:0]    lastk_r, lastk_nxt;
  logic [KW-1:0]    kmax_r, kmax_nxt;
  logic [CUM_W-1:0] cum_r, cum_nxt;
  logic [SPD_W-1:0] prev_r, prev_nxt;
  logic [SPD_W-1:0] spd_r, spd_nxt;
  logic [STP_W-1:0] stp_r, stp_nxt;
  logic [PROD_W-1:0] prod_r;

  // Memory ports
  logic             pt_we;
  logic [PT_W-1:0]  pt_rd;
  logic             stp_we;
  logic [AW-1:0]    stp_ra;
  logic [STP_W-1:0] stp_rd;
  logic             k_we;
  logic [AW-1:0]    k_wa, k_ra;
  logic [KW-1:0]    k_wd, k_rd;
  logic             sp_we;
  logic [AW-1:0]    sp_wa;
  logic [SPD_W-1:0] sp_wd, sp_rd;

  // Arithmetic unit ports
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic              div_start, sq_start;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic [SQ_W-1:0]   sq_val;
  logic [SQ_RW-1:0]  sq_root;
  unit_stat_t        div_stat, sq_stat;

  // Helpers
  logic [CW-1:0]          cnt_full, nm1, jm1;
  logic signed [PT_XW:0]  dx, dy;
  logic [PT_XW-1:0]       adx, ady;
  logic signed [17:0]     dh, dh1, dh2;
  logic [14:0]            adh;
  logic [SPD_W-1:0]       vmin, vend, ceil_q, ceil_v, ramp_v, end_cl;
  logic [CUM_W-1:0]       cum_sum;

  assign cnt_full = (cnt_r < CW'(MAX_POINTS)) ? cnt_r + 1'b1 : cnt_r;
  assign nm1      = n_r - 1'b1;
  assign jm1      = j_r - 1'b1;
  assign vmin     = (minsp_r > ONE_Q16) ? ONE_Q16 : minsp_r;
  assign vend     = (endsp_r > ONE_Q16) ? ONE_Q16 : endsp_r;

  // Segment geometry from the previous and the current point
  assign dx  = $signed({pt_rd[PT_XW-1], pt_rd[PT_XW-1:0]}) -
               $signed({prev_x_r[PT_XW-1], prev_x_r});
  assign dy  = $signed({cur_y_r[PT_XW-1], cur_y_r}) - $signed({prev_y_r[PT_XW-1], prev_y_r});
  assign adx = dx[PT_XW] ? PT_XW'(-dx) : dx[PT_XW-1:0];
  assign ady = dy[PT_XW] ? PT_XW'(-dy) : dy[PT_XW-1:0];

  // Wrap the heading change into half a turn each way
  assign dh  = $signed({cur_h_r[PT_HW-1], cur_h_r}) - $signed({prev_h_r[PT_HW-1], prev_h_r});
  assign dh1 = (dh > HALF_TURN) ? dh - FULL_TURN : ((dh < -HALF_TURN) ? dh + FULL_TURN : dh);
  assign dh2 = (dh1 > HALF_TURN) ? dh1 - FULL_TURN :
               ((dh1 < -HALF_TURN) ? dh1 + FULL_TURN : dh1);
  assign adh = dh2[17] ? 15'(-dh2) : dh2[14:0];

  // Speed ceiling, ramp limit and end clamp
  assign ceil_q  = (div_quo > DIV_NW'(ONE_Q16)) ? ONE_Q16 : div_quo[SPD_W-1:0];
  assign ceil_v  = (ceil_q < vmin) ? vmin : ceil_q;
  assign ramp_v  = (sq_root < SQ_RW'(spd_r)) ? sq_root[SPD_W-1:0] : spd_r;
  assign end_cl  = (prev_r > vend) ? vend : prev_r;
  assign cum_sum = cum_r + CUM_W'(stp_rd);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r  <= 24'd7680;
      gain_r  <= 16'd256;
      minsp_r <= 17'd6554;
      accel_r <= 24'd65536;
      endsp_r <= 17'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LOOK_AHEAD: look_r  <= cfg_data;
        CFG_CURVE_GAIN: gain_r  <= cfg_data[15:0];
        CFG_MIN_SPEED:  minsp_r <= cfg_data[SPD_W-1:0];
        CFG_ACCEL:      accel_r <= cfg_data;
        CFG_END_SPEED:  endsp_r <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_G_DX:  begin mul_a = MUL_W'(adx);     mul_b = MUL_W'(adx);     end
      S_G_DY:  begin mul_a = MUL_W'(ady);     mul_b = MUL_W'(ady);     end
      S_G_SQW: begin mul_a = MUL_W'(adh);     mul_b = PI_OVER_90_Q32;  end
      S_C_MUL: begin mul_a = MUL_W'(gain_r);  mul_b = MUL_W'(kmax_r);  end
      S_R_SQ:  begin mul_a = MUL_W'(prev_r);  mul_b = MUL_W'(prev_r);  end
      S_R_AS:  begin mul_a = MUL_W'(accel_r); mul_b = MUL_W'(stp_r);   end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Divider and square root operands
  assign div_start = (state_r == S_G_DIV) || (state_r == S_C_DEN);
  assign div_num   = (state_r == S_G_DIV) ? DIV_NW'(prod_r[42:16]) : DIV_NW'(1) << 40;
  assign div_den   = (state_r == S_G_DIV) ? DIV_DW'(d_r) :
                     (DIV_DW'(1) << 24) + prod_r[DIV_DW-1:0];
  assign sq_start  = (state_r == S_G_SQ) || (state_r == S_R_ST);
  assign sq_val    = (state_r == S_G_SQ) ? sq_r + prod_r[SQ_W-1:0] :
                     sq_r + {prod_r[SQ_W-2:0], 1'b0};

  // Memory addresses and write data
  assign pt_we  = (state_r == S_LOAD) && in_tvalid && (cnt_r < CW'(MAX_POINTS));
  assign stp_we = (state_r == S_G_SQW) && sq_stat.done;
  assign stp_ra = (state_r == S_C_CHK) ? jm1[AW-1:0] :
                  (back_r ? idx_r[AW-1:0] : AW'(idx_r - 1'b1));
  assign k_we   = ((state_r == S_G_DIVW) && div_stat.done) || (state_r == S_G_TAIL);
  assign k_wa   = (state_r == S_G_TAIL) ? nm1[AW-1:0] : AW'(idx_r - 1'b1);
  assign k_wd   = (state_r == S_G_TAIL) ? lastk_r : div_quo[KW-1:0];
  assign k_ra   = (state_r == S_C_CHK) ? j_r[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    sp_we = 1'b0;
    sp_wa = idx_r[AW-1:0];
    sp_wd = ramp_v;
    case (state_r)
      S_ONE:    begin sp_we = 1'b1;           sp_wa = '0; sp_wd = vend;   end
      S_C_DIVW: begin sp_we = div_stat.done;  sp_wd = ceil_v;             end
      S_F_INIT: begin sp_we = 1'b1;           sp_wa = '0; sp_wd = '0;     end
      S_R_W:    begin sp_we = sq_stat.done;   sp_wd = ramp_v;             end
      S_F_END:  begin sp_we = 1'b1; sp_wa = nm1[AW-1:0]; sp_wd = end_cl;  end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    idx_nxt    = idx_r;
    j_nxt      = j_r;
    back_nxt   = back_r;
    oval_nxt   = oval_r;
    olast_nxt  = olast_r;
    ospd_nxt   = ospd_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    prev_h_nxt = prev_h_r;
    cur_y_nxt  = cur_y_r;
    cur_h_nxt  = cur_h_r;
    sq_nxt     = sq_r;
    d_nxt      = d_r;
    lastk_nxt  = lastk_r;
    kmax_nxt   = kmax_r;
    cum_nxt    = cum_r;
    prev_nxt   = prev_r;
    spd_nxt    = spd_r;
    stp_nxt    = stp_r;
    case (state_r)
      // Collect waypoints; the last one starts the computation
      S_LOAD: begin
        if (in_tvalid) begin
          cnt_nxt = cnt_full;
          if (in_tlast) begin
            n_nxt     = cnt_full;
            cnt_nxt   = '0;
            idx_nxt   = '0;
            state_nxt = (cnt_full == CW'(1)) ? S_ONE : S_G_RD0;
          end
        end
      end
      S_ONE:    state_nxt = S_O_RD;
      // Step length and curvature of each segment
      S_G_RD0:  state_nxt = S_G_PREV;
      S_G_PREV: begin
        prev_x_nxt = pt_rd[PT_XW-1:0];
        prev_y_nxt = pt_rd[2*PT_XW-1:PT_XW];
        prev_h_nxt = pt_rd[PT_W-1:2*PT_XW];
        idx_nxt    = CW'(1);
        state_nxt  = S_G_RD;
      end
      S_G_RD:   state_nxt = S_G_DX;
      S_G_DX: begin
        cur_y_nxt  = pt_rd[2*PT_XW-1:PT_XW];
        cur_h_nxt  = pt_rd[PT_W-1:2*PT_XW];
        prev_x_nxt = pt_rd[PT_XW-1:0];
        state_nxt  = S_G_DY;
      end
      S_G_DY: begin
        sq_nxt    = prod_r[SQ_W-1:0];
        state_nxt = S_G_SQ;
      end
      S_G_SQ:   state_nxt = S_G_SQW;
      S_G_SQW: begin
        if (sq_stat.done) begin
          d_nxt     = (sq_root == '0) ? STP_W'(1) : sq_root[STP_W-1:0];
          state_nxt = S_G_DIV;
        end
      end
      S_G_DIV:  state_nxt = S_G_DIVW;
      S_G_DIVW: begin
        if (div_stat.done) begin
          lastk_nxt  = div_quo[KW-1:0];
          prev_y_nxt = cur_y_r;
          prev_h_nxt = cur_h_r;
          if (idx_r == nm1) begin
            state_nxt = S_G_TAIL;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_G_RD;
          end
        end
      end
      S_G_TAIL: begin
        idx_nxt   = '0;
        state_nxt = S_C_RD;
      end
      // Worst curvature in the look-ahead window, then the speed ceiling
      S_C_RD:   state_nxt = S_C_K;
      S_C_K: begin
        kmax_nxt  = k_rd;
        cum_nxt   = '0;
        j_nxt     = idx_r + 1'b1;
        state_nxt = S_C_CHK;
      end
      S_C_CHK:  state_nxt = (j_r >= n_r) ? S_C_MUL : S_C_WIN;
      S_C_WIN: begin
        cum_nxt = cum_sum;
        if (cum_sum > CUM_W'(look_r)) begin
          state_nxt = S_C_MUL;
        end else begin
          if (k_rd > kmax_r) begin
            kmax_nxt = k_rd;
          end
          j_nxt     = j_r + 1'b1;
          state_nxt = S_C_CHK;
        end
      end
      S_C_MUL:  state_nxt = S_C_DEN;
      S_C_DEN:  state_nxt = S_C_DIVW;
      S_C_DIVW: begin
        if (div_stat.done) begin
          if (idx_r == nm1) begin
            state_nxt = S_F_INIT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_C_RD;
          end
        end
      end
      // Acceleration ramp from rest, then deceleration ramp to the end speed
      S_F_INIT: begin
        prev_nxt  = '0;
        idx_nxt   = CW'(1);
        back_nxt  = 1'b0;
        state_nxt = S_R_RD;
      end
      S_R_RD:   state_nxt = S_R_SQ;
      S_R_SQ: begin
        spd_nxt   = sp_rd;
        stp_nxt   = stp_rd;
        state_nxt = S_R_AS;
      end
      S_R_AS: begin
        sq_nxt    = prod_r[SQ_W-1:0];
        state_nxt = S_R_ST;
      end
      S_R_ST:   state_nxt = S_R_W;
      S_R_W: begin
        if (sq_stat.done) begin
          prev_nxt = ramp_v;
          if (!back_r) begin
            if (idx_r == nm1) begin
              state_nxt = S_F_END;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_R_RD;
            end
          end else if (idx_r == '0) begin
            state_nxt = S_O_RD;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_R_RD;
          end
        end
      end
      S_F_END: begin
        prev_nxt  = end_cl;
        idx_nxt   = n_r - CW'(2);
        back_nxt  = 1'b1;
        state_nxt = S_R_RD;
      end
      // Deliver one speed per point
      S_O_RD:   state_nxt = S_O_LD;
      S_O_LD: begin
        ospd_nxt  = sp_rd;
        olast_nxt = (idx_r == nm1);
        oval_nxt  = 1'b1;
        state_nxt = S_O_W;
      end
      S_O_W: begin
        if (out_tready) begin
          oval_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_O_RD;
          end
        end
      end
      default:  state_nxt = S_LOAD;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      idx_r   <= '0;
      j_r     <= '0;
      back_r  <= 1'b0;
      oval_r  <= 1'b0;
      olast_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
      j_r     <= j_nxt;
      back_r  <= back_nxt;
      oval_r  <= oval_nxt;
      olast_r <= olast_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    ospd_r   <= ospd_nxt;
    prev_x_r <= prev_x_nxt;
    prev_y_r <= prev_y_nxt;
    prev_h_r <= prev_h_nxt;
    cur_y_r  <= cur_y_nxt;
    cur_h_r  <= cur_h_nxt;
    sq_r     <= sq_nxt;
    d_r      <= d_nxt;
    lastk_r  <= lastk_nxt;
    kmax_r   <= kmax_nxt;
    cum_r    <= cum_nxt;
    prev_r   <= prev_nxt;
    spd_r    <= spd_nxt;
    stp_r    <= stp_nxt;
  end

  // Stores
  clvp_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(cnt_r[AW-1:0]), .wdata(in_tdata[PT_W-1:0]),
    .raddr(idx_r[AW-1:0]), .rdata(pt_rd)
  );

  clvp_ram #(.WIDTH(STP_W), .DEPTH(MAX_POINTS)) u_stp_ram (
    .clk(clk), .we(stp_we), .waddr(AW'(idx_r - 1'b1)), .wdata(d_nxt),
    .raddr(stp_ra), .rdata(stp_rd)
  );

  clvp_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_k_ram (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
  );

  clvp_ram #(.WIDTH(SPD_W), .DEPTH(MAX_POINTS)) u_sp_ram (
    .clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd),
    .raddr(idx_r[AW-1:0]), .rdata(sp_rd)
  );

  // Shared iterative units
  clvp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .stat(div_stat), .quo(div_quo)
  );

  clvp_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(sq_val),
    .stat(sq_stat), .root(sq_root)
  );

  // Ports
  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = oval_r;
  assign out_tdata  = {7'b0, ospd_r};
  assign out_tlast  = olast_r;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_stat.busy && sq_stat.busy))
    else $error("divider and square root busy together");

  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("not ready for a new path after the final speed");

endmodule

### verif/tb_curvature_limited_velocity_profile.sv
// Testbench for the curvature-limited velocity profile: directed and random paths vs a predictor.
module tb_curvature_limited_velocity_profile
  import clvp_pkg::*;
();

  localparam int NPTS = 64;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [71:0]       in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  typedef struct {
    logic [16:0] speed;
    logic        final_point;
  } speed_exp_t;

  speed_exp_t speed_q[$];
  int         err_cnt;
  int         send_idle_pct;
  int         recv_idle_pct;

  // Predictor state
  logic [23:0] p_look;
  logic [15:0] p_gain;
  logic [16:0] p_vmin_reg;
  logic [23:0] p_accel;
  logic [16:0] p_vend_reg;
  int          p_count;
  longint      px[NPTS];
  longint      py[NPTS];
  longint      ph[NPTS];

  curvature_limited_velocity_profile u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Run limit
  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned ramp_speed(longint unsigned v, longint unsigned st);
    longint unsigned r;
    r = int_sqrt(v * v + 2 * longint'(p_accel) * st);
    return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
  endfunction

  function automatic longint unsigned sat_speed(longint unsigned v);
    return (v > 65536) ? 65536 : v;
  endfunction

  // Compute the profile over held points and queue its speeds
  task automatic predict_profile();
    longint unsigned stp[NPTS];
    longint unsigned kc[NPTS];
    longint unsigned spd[NPTS];
    longint unsigned vmin, vend, kmax, cum, v, a;
    longint dx, dy, dh;
    int n;
    speed_exp_t e;
    n = p_count;
    p_count = 0;
    vmin = sat_speed(p_vmin_reg);
    vend = sat_speed(p_vend_reg);
    if (n == 1) begin
      spd[0] = vend;
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        dx = px[i+1] - px[i];
        dy = py[i+1] - py[i];
        stp[i] = int_sqrt(dx * dx + dy * dy);
        if (stp[i] == 0) stp[i] = 1;
        dh = ph[i+1] - ph[i];
        while (dh > 23040) dh -= 46080;
        while (dh < -23040) dh += 46080;
        if (dh < 0) dh = -dh;
        kc[i] = (longint'(dh) * 149922641) / (stp[i] << 16);
      end
      kc[n-1] = kc[n-2];
      for (int i = 0; i < n; i++) begin
        kmax = kc[i];
        cum = 0;
        for (int j = i + 1; j < n; j++) begin
          cum += stp[j-1];
          if (cum > p_look) break;
          if (kc[j] > kmax) kmax = kc[j];
        end
        v = (64'd1 << 40) / ((64'd1 << 24) + longint'(p_gain) * kmax);
        if (v > 65536) v = 65536;
        if (v < vmin) v = vmin;
        spd[i] = v;
      end
      spd[0] = 0;
      for (int i = 1; i < n; i++) begin
        a = ramp_speed(spd[i-1], stp[i-1]);
        if (a < spd[i]) spd[i] = a;
      end
      if (spd[n-1] > vend) spd[n-1] = vend;
      for (int i = n - 2; i >= 0; i--) begin
        a = ramp_speed(spd[i+1], stp[i]);
        if (a < spd[i]) spd[i] = a;
      end
    end
    for (int i = 0; i < n; i++) begin
      e.speed = spd[i][16:0];
      e.final_point = (i == n - 1);
      speed_q.insert(speed_q.size(), e);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // Send one waypoint transaction and update the predictor on acceptance
  task automatic send_point(logic [23:0] x, logic [23:0] y, logic [16:0] h, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, h, y, x};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (p_count < NPTS) begin
      px[p_count] = longint'($signed(x));
      py[p_count] = longint'($signed(y));
      ph[p_count] = longint'($signed(h));
      p_count++;
    end
    if (last) predict_profile();
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_LOOK_AHEAD: p_look = val;
      CFG_CURVE_GAIN: p_gain = val[15:0];
      CFG_MIN_SPEED:  p_vmin_reg = val[16:0];
      CFG_ACCEL:      p_accel = val;
      CFG_END_SPEED:  p_vend_reg = val[16:0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (speed_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [16:0] rand_heading();
    return 17'($signed($urandom_range(92160)) - 46080);
  endfunction

  // Receiver: random stall and result check
  always @(posedge clk) begin
    speed_exp_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (speed_q.size() == 0) begin
          report_mismatch("speed with none expected");
        end else begin
          e = speed_q.pop_front();
          if (out_tdata[16:0] !== e.speed)
            report_mismatch($sformatf("speed %0d exp %0d", out_tdata[16:0], e.speed));
          if (out_tlast !== e.final_point)
            report_mismatch($sformatf("final_point %0b exp %0b", out_tlast, e.final_point));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Extremes of the fields, single point, wrap of heading, zero step
  task automatic test_directed();
    send_point(24'h7FFFFF, 24'h800000, 17'(46080), 1'b1);
    send_point(24'h800000, 24'h800000, 17'(-46080), 1'b0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 17'(46080), 1'b0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 17'(-23041), 1'b0);
    send_point(24'h000100, 24'h000000, 17'(23040), 1'b0);
    send_point(24'h000100, 24'h000300, 17'h1FFFF, 1'b1);
    send_point(24'h0, 24'h0, 17'h0, 1'b0);
    send_point(24'h0, 24'h0, 17'(23041), 1'b1);
    wait_drain();
  endtask

  // Fill past capacity; the dropped last item still starts the computation
  task automatic test_overflow();
    for (int i = 0; i < 66; i++)
      send_point(24'(i * 2560), 24'($urandom_range(4000)), 17'($urandom_range(2000)),
                 i == 65);
    wait_drain();
  endtask

  // Random smooth paths with random content, plus noise points
  task automatic test_random(int items);
    int sent, n;
    logic [23:0] x, y;
    logic [16:0] h;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
      x = 24'($urandom);
      y = 24'($urandom);
      h = rand_heading();
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(4) == 0) begin
          x = 24'($urandom);
          y = 24'($urandom);
          h = rand_heading();
        end else begin
          x = x + 24'($signed($urandom_range(8000)) - 4000);
          y = y + 24'($signed($urandom_range(8000)) - 4000);
          h = 17'($signed(h) + $signed($urandom_range(4000)) - 2000);
          if ($signed(h) > 46080 || $signed(h) < -46080) h = 17'd0;
        end
        send_point(x, y, h, i == n - 1);
      end
      sent += n;
    end
    wait_drain();
  endtask

  task automatic set_regs(logic [23:0] la, logic [23:0] g, logic [23:0] vm,
                          logic [23:0] ac, logic [23:0] ve);
    write_reg(CFG_LOOK_AHEAD, la);
    write_reg(CFG_CURVE_GAIN, g);
    write_reg(CFG_MIN_SPEED, vm);
    write_reg(CFG_ACCEL, ac);
    write_reg(CFG_END_SPEED, ve);
    cfg_we <= 1'b0;
  endtask

  initial begin
    err_cnt = 0;
    send_idle_pct = 30;
    recv_idle_pct = 51;
    p_look = 24'd7680;
    p_gain = 16'd256;
    p_vmin_reg = 17'd6554;
    p_accel = 24'd65536;
    p_vend_reg = 17'd0;
    p_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_regs(24'hFFFFFF, 24'hFFFF, 24'h1FFFF, 24'hFFFFFF, 24'h1FFFF);
    test_directed();
    test_overflow();
    set_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    test_random(10);
    send_idle_pct = 51;
    recv_idle_pct = 30;
    set_regs(24'd2000, 24'd3000, 24'd10000, 24'd20000, 24'd30000);
    test_random(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(24'd7680, 24'd256, 24'd6554, 24'd65536, 24'd0);
    test_random(30);

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/clvp_pkg.sv
hw/rtl/clvp_ram.sv
hw/rtl/clvp_div.sv
hw/rtl/clvp_sqrt.sv
hw/rtl/curvature_limited_velocity_profile.sv
verif/tb_curvature_limited_velocity_profile.sv
